// ===== sv/cvmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Core VM mode tracker package
// Shared types and constants for the core mode and machine slot tracker.
// ----------------------------------------------------------------------------
package cvmt_pkg;

    localparam int TAG_W  = 64;
    localparam int CORE_W = 3;
    localparam int SLOT_W = 4;

    localparam logic [TAG_W-1:0] TAG_ONES = {TAG_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_QUERY = 2'd2,
        OP_RSVD  = 2'd3
    } opcode_t;

    typedef struct packed {
        logic eq;
        logic a_ones;
        logic a_zero;
    } cmp_res_t;

endpackage

// ===== sv/cvmt_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// Tag compare unit
// Shared 64-bit comparator: equality of two tags plus all-ones and zero tests.
// ----------------------------------------------------------------------------
module cvmt_cmp_unit (
    input  logic [cvmt_pkg::TAG_W-1:0] a,
    input  logic [cvmt_pkg::TAG_W-1:0] b,
    output cvmt_pkg::cmp_res_t         res
);

    assign res.eq     = (a == b);
    assign res.a_ones = &a;
    assign res.a_zero = ~|a;

endmodule

// ===== sv/cvmt_tag_store.sv =====
// ----------------------------------------------------------------------------
// Tag store
// Single-port-write, registered-read tag memory with per-entry valid bits.
// An entry never written reads as all ones, or as zero for entry 0 when
// FIRST_ZERO is set.
// ----------------------------------------------------------------------------
module cvmt_tag_store #(
    parameter int DEPTH      = 8,
    parameter bit FIRST_ZERO = 1'b0,
    parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [cvmt_pkg::TAG_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [cvmt_pkg::TAG_W-1:0] rd_data
);

    logic [cvmt_pkg::TAG_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           vld_reg;
    logic [cvmt_pkg::TAG_W-1:0] rd_data_reg;
    logic                       rd_vld_reg;
    logic                       rd_first_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg   <= vld_reg[rd_addr];
                rd_first_reg <= (rd_addr == '0);
            end
        end
    end

    always_comb begin
        if (rd_vld_reg) begin
            rd_data = rd_data_reg;
        end else if (FIRST_ZERO && rd_first_reg) begin
            rd_data = '0;
        end else begin
            rd_data = cvmt_pkg::TAG_ONES;
        end
    end

endmodule

// ===== sv/core_vm_mode_tracker.sv =====
// ----------------------------------------------------------------------------
// Core VM mode tracker
// Tracks the machine each core runs and assigns dense slot numbers to tags.
// ----------------------------------------------------------------------------
// Each input beat carries an opcode (enter, exit, query), a core number and a
// 64-bit machine tag; each produces exactly one result beat with a status
// bit and a 4-bit slot number. Both channels use valid and ready.
// The block works on one beat at a time. A beat that needs no slot walk passes
// through the mode read, decide and finish states to the result register, and
// s_ready returns in the same cycle as the result is loaded.
// Entry, exit with a tag and query of a machine walk the slot table through
// its single read port, one slot per cycle, with one shared 64-bit
// comparator; the walk stops at the first matching or empty slot.
// The result sits in an output register, so a new beat is accepted as soon
// as the result is loaded, even while the receiver stalls; the block stalls
// only when a second result is ready before the first was taken.
// After reset every core reads as never entered, slot 0 holds the
// hypervisor and all other slots are empty; no clearing pass is needed and
// s_ready is already high when reset is released.
// ----------------------------------------------------------------------------
module core_vm_mode_tracker #(
    parameter int CORES    = 8,
    parameter int VM_SLOTS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [cvmt_pkg::CORE_W-1:0] s_core,
    input  logic [cvmt_pkg::TAG_W-1:0]  s_vm_tag,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic [cvmt_pkg::SLOT_W-1:0] m_vm_slot
);

    localparam int CORE_AW = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int SLOT_AW = $clog2(VM_SLOTS);
    localparam int SLOT_CW = $clog2(VM_SLOTS + 1);
    localparam logic [8:0]         CORES_LIM = 9'(CORES);
    localparam logic [SLOT_CW-1:0] SLOT_END  = SLOT_CW'(VM_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODE_RD,
        ST_DECIDE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t                        state_reg;
    cvmt_pkg::opcode_t             op_reg;
    logic [cvmt_pkg::CORE_W-1:0]   core_reg;
    logic [cvmt_pkg::TAG_W-1:0]    tag_reg;
    logic [cvmt_pkg::TAG_W-1:0]    key_reg;
    logic [SLOT_CW-1:0]            cnt_reg;
    logic [SLOT_AW-1:0]            cmp_idx_reg;
    logic                          pend_reg;
    logic                          status_reg;
    logic [cvmt_pkg::SLOT_W-1:0]   slot_reg;
    logic                          m_valid_reg;
    logic                          m_status_reg;
    logic [cvmt_pkg::SLOT_W-1:0]   m_vm_slot_reg;

    logic [CORE_AW+cvmt_pkg::CORE_W-1:0] core_ext;
    logic [CORE_AW-1:0]                  core_addr;
    logic                                core_ok;
    logic [SLOT_AW+cvmt_pkg::SLOT_W-1:0] idx_ext;
    logic [cvmt_pkg::TAG_W-1:0]          mode_rdata;
    logic [cvmt_pkg::TAG_W-1:0]          slot_rdata;
    logic [cvmt_pkg::TAG_W-1:0]          cmp_a;
    logic [cvmt_pkg::TAG_W-1:0]          cmp_b;
    cvmt_pkg::cmp_res_t                  cmp;

    logic                         dec_status;
    logic                         dec_walk;
    logic                         dec_wr;
    logic [cvmt_pkg::TAG_W-1:0]   dec_wr_data;
    logic [cvmt_pkg::TAG_W-1:0]   dec_key;

    logic mode_rd_en;
    logic mode_wr_en;
    logic walk_stop;
    logic slot_rd_en;
    logic slot_wr_en;
    logic out_free;
    logic out_load;

    assign core_ext  = {CORE_AW'(0), core_reg};
    assign core_addr = core_ext[CORE_AW-1:0];
    assign core_ok   = ({6'd0, core_reg} < CORES_LIM);
    assign idx_ext   = {cvmt_pkg::SLOT_W'(0), cmp_idx_reg};

    assign mode_rd_en = (state_reg == ST_MODE_RD);
    assign mode_wr_en = (state_reg == ST_DECIDE) && dec_wr;

    assign cmp_a = (state_reg == ST_DECIDE) ? mode_rdata : slot_rdata;
    assign cmp_b = (state_reg == ST_DECIDE) ? tag_reg : key_reg;

    assign walk_stop  = (state_reg == ST_WALK) && pend_reg && (cmp.eq || cmp.a_ones);
    assign slot_rd_en = (state_reg == ST_WALK) && !walk_stop && (cnt_reg != SLOT_END);
    assign slot_wr_en = walk_stop && (op_reg != cvmt_pkg::OP_QUERY) && !cmp.eq;

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_FINISH) && out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_vm_slot = m_vm_slot_reg;

    cvmt_tag_store #(
        .DEPTH      (CORES),
        .FIRST_ZERO (1'b0)
    ) u_mode_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mode_wr_en),
        .wr_addr (core_addr),
        .wr_data (dec_wr_data),
        .rd_en   (mode_rd_en),
        .rd_addr (core_addr),
        .rd_data (mode_rdata)
    );

    cvmt_tag_store #(
        .DEPTH      (VM_SLOTS),
        .FIRST_ZERO (1'b1)
    ) u_slot_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (slot_wr_en),
        .wr_addr (cmp_idx_reg),
        .wr_data (key_reg),
        .rd_en   (slot_rd_en),
        .rd_addr (cnt_reg[SLOT_AW-1:0]),
        .rd_data (slot_rdata)
    );

    cvmt_cmp_unit u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp)
    );

    always_comb begin
        dec_status  = 1'b0;
        dec_walk    = 1'b0;
        dec_wr      = 1'b0;
        dec_wr_data = '0;
        dec_key     = tag_reg;
        priority if (op_reg == cvmt_pkg::OP_RSVD) begin
            dec_status = 1'b0;
        end else if (!core_ok) begin
            dec_status = 1'b1;
        end else begin
            unique case (op_reg)
                cvmt_pkg::OP_ENTER: begin
                    if (cmp.a_zero || cmp.a_ones) begin
                        dec_wr      = 1'b1;
                        dec_wr_data = tag_reg;
                        dec_walk    = 1'b1;
                    end else begin
                        dec_status = 1'b1;
                    end
                end
                cvmt_pkg::OP_EXIT: begin
                    if (cmp.a_ones) begin
                        dec_wr = 1'b1;
                    end else if (cmp.eq) begin
                        dec_wr   = 1'b1;
                        dec_walk = 1'b1;
                    end else begin
                        dec_status = 1'b1;
                    end
                end
                cvmt_pkg::OP_QUERY: begin
                    if (!(cmp.a_zero || cmp.a_ones)) begin
                        dec_walk = 1'b1;
                        dec_key  = mode_rdata;
                    end
                end
                default: begin
                    dec_status = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= cvmt_pkg::opcode_t'(s_opcode);
                        core_reg  <= s_core;
                        tag_reg   <= s_vm_tag;
                        state_reg <= ST_MODE_RD;
                    end
                end
                ST_MODE_RD: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    status_reg <= dec_status;
                    slot_reg   <= '0;
                    key_reg    <= dec_key;
                    cnt_reg    <= '0;
                    pend_reg   <= 1'b0;
                    state_reg  <= dec_walk ? ST_WALK : ST_FINISH;
                end
                ST_WALK: begin
                    if (walk_stop) begin
                        if (op_reg == cvmt_pkg::OP_QUERY && cmp.eq) begin
                            slot_reg <= idx_ext[cvmt_pkg::SLOT_W-1:0];
                        end
                        pend_reg  <= 1'b0;
                        state_reg <= ST_FINISH;
                    end else if (slot_rd_en) begin
                        cmp_idx_reg <= cnt_reg[SLOT_AW-1:0];
                        pend_reg    <= 1'b1;
                        cnt_reg     <= cnt_reg + SLOT_CW'(1);
                    end else begin
                        pend_reg <= 1'b0;
                        if (!pend_reg) begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_status_reg  <= status_reg;
                        m_vm_slot_reg <= slot_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/sv/core_vm_mode_tracker_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core VM mode tracker result checker
// Watches both channels of the tracker, keeps its own copy of the core modes
// and the slot table, works out the reply of every accepted input beat and
// compares each result beat, field by field, with the oldest pending reply.
// ----------------------------------------------------------------------------
module core_vm_mode_tracker_check #(
    parameter int CORES    = 8,
    parameter int VM_SLOTS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  cvmt_pkg::opcode_t           s_opcode,
    input  logic [cvmt_pkg::CORE_W-1:0] s_core,
    input  logic [cvmt_pkg::TAG_W-1:0]  s_vm_tag,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_status,
    input  logic [cvmt_pkg::SLOT_W-1:0] m_vm_slot,
    output int                          mismatches,
    output int                          outstanding
);

    typedef struct packed {
        logic                        status;
        logic [cvmt_pkg::SLOT_W-1:0] slot;
    } vm_reply_t;

    logic [cvmt_pkg::TAG_W-1:0] mode_of_cpu [CORES];
    logic [cvmt_pkg::TAG_W-1:0] slot_tag [VM_SLOTS];
    vm_reply_t                  pending_replies [$];

    function automatic void register_vm_tag(logic [cvmt_pkg::TAG_W-1:0] tag);
        for (int s = 0; s < VM_SLOTS; s++) begin
            if (slot_tag[s] == tag) begin
                return;
            end
            if (slot_tag[s] == cvmt_pkg::TAG_ONES) begin
                slot_tag[s] = tag;
                return;
            end
        end
    endfunction

    function automatic vm_reply_t apply_vm_event(cvmt_pkg::opcode_t op,
                                                 logic [cvmt_pkg::CORE_W-1:0] core,
                                                 logic [cvmt_pkg::TAG_W-1:0] tag);
        vm_reply_t                  r;
        logic [cvmt_pkg::TAG_W-1:0] mode;
        r = '0;
        if (op == cvmt_pkg::OP_RSVD) begin
            return r;
        end
        if (int'(core) >= CORES) begin
            r.status = 1'b1;
            return r;
        end
        mode = mode_of_cpu[core];
        unique case (op)
            cvmt_pkg::OP_ENTER: begin
                if (mode == '0 || mode == cvmt_pkg::TAG_ONES) begin
                    mode_of_cpu[core] = tag;
                    register_vm_tag(tag);
                end else begin
                    r.status = 1'b1;
                end
            end
            cvmt_pkg::OP_EXIT: begin
                if (mode == cvmt_pkg::TAG_ONES) begin
                    mode_of_cpu[core] = '0;
                end else if (mode == tag) begin
                    mode_of_cpu[core] = '0;
                    register_vm_tag(tag);
                end else begin
                    r.status = 1'b1;
                end
            end
            cvmt_pkg::OP_QUERY: begin
                if (mode != '0 && mode != cvmt_pkg::TAG_ONES) begin
                    for (int s = 0; s < VM_SLOTS; s++) begin
                        if (slot_tag[s] == mode) begin
                            r.slot = s[cvmt_pkg::SLOT_W-1:0];
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic log_miss(vm_reply_t want, logic orphan);
        mismatches++;
        if (mismatches <= 10) begin
            if (orphan) begin
                $display("%0t: result beat with nothing pending: status %b slot %0d",
                         $realtime, m_status, m_vm_slot);
            end else begin
                $display("%0t: result mismatch: expected status %b slot %0d,",
                         $realtime, want.status, want.slot,
                         " got status %b slot %0d", m_status, m_vm_slot);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        vm_reply_t want;
        if (!aresetn) begin
            for (int c = 0; c < CORES; c++) begin
                mode_of_cpu[c] = cvmt_pkg::TAG_ONES;
            end
            for (int s = 0; s < VM_SLOTS; s++) begin
                slot_tag[s] = cvmt_pkg::TAG_ONES;
            end
            slot_tag[0] = '0;
            pending_replies.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    log_miss('0, 1'b1);
                end else begin
                    want = pending_replies.pop_front();
                    if (m_status !== want.status || m_vm_slot !== want.slot) begin
                        log_miss(want, 1'b0);
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_replies.push_back(apply_vm_event(s_opcode, s_core, s_vm_tag));
            end
        end
        outstanding <= pending_replies.size();
    end

endmodule

// ===== tb/sv/core_vm_mode_tracker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Core VM mode tracker testbench
// Drives enter, exit, query and reserved beats through the tracker, first a directed
// sequence over the corner cases and then random core sessions, with bursty
// input traffic and a stalling receiver; the checker judges every result.
// ----------------------------------------------------------------------------
module core_vm_mode_tracker_test;

    localparam int CORES        = 8;
    localparam int VM_SLOTS     = 16;
    localparam int RANDOM_BEATS = 600;
    localparam int POOL_SIZE    = 24;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    cvmt_pkg::opcode_t           s_opcode;
    logic [cvmt_pkg::CORE_W-1:0] s_core;
    logic [cvmt_pkg::TAG_W-1:0]  s_vm_tag;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic                        m_status;
    logic [cvmt_pkg::SLOT_W-1:0] m_vm_slot;
    int                          mismatches;
    int                          outstanding;

    logic [cvmt_pkg::TAG_W-1:0]  mode_shadow [CORES];
    logic [cvmt_pkg::TAG_W-1:0]  tag_pool [POOL_SIZE];
    int                          burst_left;
    int                          ready_mode;
    int                          ready_left;
    int                          tick;

    core_vm_mode_tracker #(
        .CORES    (CORES),
        .VM_SLOTS (VM_SLOTS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_core    (s_core),
        .s_vm_tag  (s_vm_tag),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_vm_slot (m_vm_slot)
    );

    core_vm_mode_tracker_check #(
        .CORES    (CORES),
        .VM_SLOTS (VM_SLOTS)
    ) i_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_core      (s_core),
        .s_vm_tag    (s_vm_tag),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_vm_slot   (m_vm_slot),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 4);
            ready_left <= $urandom_range(32, 256);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            3:       m_ready <= (tick % 7 == 0);
            default: m_ready <= (tick % 40 == 0);
        endcase
        tick <= tick + 1;
    end

    task automatic send_beat(cvmt_pkg::opcode_t op, logic [cvmt_pkg::CORE_W-1:0] core,
                             logic [cvmt_pkg::TAG_W-1:0] tag);
        int gap;
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_core   <= core;
        s_vm_tag <= tag;
        do @(posedge aclk); while (!s_ready);
        case (op)
            cvmt_pkg::OP_ENTER: begin
                if (mode_shadow[core] == '0 || mode_shadow[core] == cvmt_pkg::TAG_ONES) begin
                    mode_shadow[core] = tag;
                end
            end
            cvmt_pkg::OP_EXIT: begin
                if (mode_shadow[core] == cvmt_pkg::TAG_ONES || mode_shadow[core] == tag) begin
                    mode_shadow[core] = '0;
                end
            end
            default: ;
        endcase
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic [cvmt_pkg::TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 19))
            0:       return cvmt_pkg::TAG_ONES;
            1:       return '0;
            2:       return {$urandom, $urandom};
            default: return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
        endcase
    endfunction

    task automatic send_random_beat();
        logic [cvmt_pkg::CORE_W-1:0] core;
        logic [cvmt_pkg::TAG_W-1:0]  mode;
        int                          pick;
        int unsigned                 draw;
        draw = $urandom_range(0, CORES - 1);
        core = draw[cvmt_pkg::CORE_W-1:0];
        mode = mode_shadow[core];
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 99) >= 80) begin
            send_beat(cvmt_pkg::opcode_t'($urandom_range(0, 3)), core, pick_tag());
        end else if (mode != '0 && mode != cvmt_pkg::TAG_ONES) begin
            if (pick < 4) begin
                send_beat(cvmt_pkg::OP_QUERY, core, pick_tag());
            end else if (pick < 9) begin
                send_beat(cvmt_pkg::OP_EXIT, core, mode);
            end else begin
                send_beat(($urandom_range(0, 1) != 0) ? cvmt_pkg::OP_ENTER : cvmt_pkg::OP_EXIT,
                          core, pick_tag());
            end
        end else begin
            if (pick < 6) begin
                send_beat(cvmt_pkg::OP_ENTER, core, pick_tag());
            end else if (pick < 8) begin
                send_beat(cvmt_pkg::OP_QUERY, core, pick_tag());
            end else begin
                send_beat(cvmt_pkg::OP_EXIT, core, pick_tag());
            end
        end
    endtask

    initial begin
        logic [cvmt_pkg::TAG_W-1:0] tag_a;
        logic [cvmt_pkg::TAG_W-1:0] tag_b;
        tag_a = 64'h0123_4567_89AB_CDEF;
        tag_b = 64'hFEDC_BA98_7654_3210;
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_opcode <= cvmt_pkg::OP_ENTER;
        s_core   <= '0;
        s_vm_tag <= '0;
        burst_left = $urandom_range(1, 20);
        for (int c = 0; c < CORES; c++) begin
            mode_shadow[c] = cvmt_pkg::TAG_ONES;
        end
        for (int p = 0; p < POOL_SIZE; p++) begin
            tag_pool[p] = {$urandom, $urandom};
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(cvmt_pkg::OP_QUERY, 3'd0, '0);
        send_beat(cvmt_pkg::OP_EXIT, 3'd1, tag_b);
        send_beat(cvmt_pkg::OP_ENTER, 3'd0, tag_a);
        send_beat(cvmt_pkg::OP_QUERY, 3'd0, cvmt_pkg::TAG_ONES);
        send_beat(cvmt_pkg::OP_ENTER, 3'd0, tag_b);
        send_beat(cvmt_pkg::OP_EXIT, 3'd0, tag_b);
        send_beat(cvmt_pkg::OP_ENTER, 3'd2, tag_a);
        send_beat(cvmt_pkg::OP_QUERY, 3'd2, '0);
        send_beat(cvmt_pkg::OP_EXIT, 3'd0, tag_a);
        send_beat(cvmt_pkg::OP_QUERY, 3'd0, '0);
        send_beat(cvmt_pkg::OP_ENTER, 3'd3, cvmt_pkg::TAG_ONES);
        send_beat(cvmt_pkg::OP_QUERY, 3'd3, '0);
        send_beat(cvmt_pkg::OP_EXIT, 3'd3, cvmt_pkg::TAG_ONES);
        send_beat(cvmt_pkg::OP_ENTER, 3'd4, '0);
        send_beat(cvmt_pkg::OP_QUERY, 3'd4, '0);
        send_beat(cvmt_pkg::OP_RSVD, 3'd7, cvmt_pkg::TAG_ONES);
        send_beat(cvmt_pkg::OP_RSVD, 3'd0, '0);
        send_beat(cvmt_pkg::OP_ENTER, 3'd7, 64'h5555_5555_5555_5555);
        send_beat(cvmt_pkg::OP_QUERY, 3'd7, '0);
        send_beat(cvmt_pkg::OP_EXIT, 3'd7, 64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(cvmt_pkg::OP_EXIT, 3'd7, 64'h5555_5555_5555_5555);
        send_beat(cvmt_pkg::OP_ENTER, 3'd5, tag_b);
        send_beat(cvmt_pkg::OP_QUERY, 3'd5, cvmt_pkg::TAG_ONES);
        drain_results();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            send_random_beat();
            if (n == RANDOM_BEATS / 2) begin
                drain_results();
            end
        end
        drain_results();
        repeat (32) @(posedge aclk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/cvmt_pkg.sv
sv/cvmt_cmp_unit.sv
sv/cvmt_tag_store.sv
sv/core_vm_mode_tracker.sv
tb/sv/core_vm_mode_tracker_check.sv
tb/sv/core_vm_mode_tracker_test.sv
